// File: sv/twc_pkg.sv
// shared types and constants for the text console writer
`default_nettype none

package twc_pkg;

   localparam int KIND_W = 2;
   localparam int CODE_W = 8;
   localparam int ATTR_W = 8;
   localparam int IDX_W  = 11;
   localparam int CUR_W  = 11;
   localparam int DATA_W = 16;

   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 24;

   localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;

   // space in light grey on black
   localparam logic [DATA_W-1:0] BLANK_CELL = 16'h0720;

   typedef struct packed {
      logic latch;
      logic exec;
      logic sweep;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic start_sweep;
      logic sweep_last;
   } status_type;

endpackage

`default_nettype wire

// File: sv/twc_datapath.sv
// cell store, cursor, sweep counters and result registers
`default_nettype none

module twc_datapath import twc_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic [CODE_W-1:0] req_char_code,
   input  wire logic [ATTR_W-1:0] req_attribute,
   input  wire logic [IDX_W-1:0]  req_read_index,
   output logic [CUR_W-1:0]       rsp_cursor_now,
   output logic                   rsp_did_scroll,
   output logic [DATA_W-1:0]      rsp_cell_data
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLUMNS);

   logic [KIND_W-1:0] kind_ff;
   logic [CODE_W-1:0] code_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic [ADDR_W-1:0] cursor_ff;
   logic [COL_W-1:0]  col_ff;
   logic              scroll_ff;
   logic              copy_mode_ff;
   logic              rd_valid_ff;
   logic [CNT_W-1:0]  rd_ptr_ff;
   logic [ADDR_W-1:0] wr_ptr_ff;
   logic [DATA_W-1:0] rd_data_ff;

   logic [CUR_W-1:0]  rsp_cursor_ff;
   logic              rsp_scroll_ff;
   logic [DATA_W-1:0] rsp_data_ff;

   logic [DATA_W-1:0] cell_store_ff [CELLS];

   logic              is_put;
   logic              is_clear;
   logic              is_read;
   logic              is_print;
   logic              idx_ok;
   logic              wrap;
   logic [CNT_W-1:0]  cur_ext;
   logic [CNT_W-1:0]  cursor_in;
   logic [COL_W-1:0]  col_in;
   logic              rd_go;
   logic              blank_zone;
   logic              wr_go;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   assign is_put   = (kind_ff == KIND_PUT);
   assign is_clear = (kind_ff == KIND_CLEAR);
   assign is_read  = (kind_ff == KIND_READ);
   assign is_print = is_put && (code_ff != CODE_NEWLINE) && (code_ff != CODE_BACKSPACE);
   assign idx_ok   = (32'(idx_ff) < 32'(CELLS));
   assign cur_ext  = CNT_W'(cursor_ff);

   // cursor and column after a put item, before any scroll
   always_comb begin
      cursor_in = cur_ext;
      col_in    = col_ff;
      if (is_put) begin
         if (code_ff == CODE_NEWLINE) begin
            cursor_in = cur_ext - CNT_W'(col_ff) + CNT_W'(COLUMNS);
            col_in    = '0;
         end else if (code_ff == CODE_BACKSPACE) begin
            if (cursor_ff != '0) begin
               cursor_in = cur_ext - CNT_W'(1);
               col_in    = (col_ff == '0) ? COL_W'(COLUMNS - 1) : col_ff - COL_W'(1);
            end
         end else begin
            cursor_in = cur_ext + CNT_W'(1);
            col_in    = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);
         end
      end
   end

   assign wrap = is_put && (cursor_in == CNT_W'(CELLS));

   // sweep: on a scroll, copy rows up through the read pipeline, then blank the tail; on a clear, blank every cell
   assign rd_go      = copy_mode_ff && (rd_ptr_ff != CNT_W'(CELLS));
   assign blank_zone = !copy_mode_ff || (wr_ptr_ff >= ADDR_W'(CELLS - COLUMNS));
   assign wr_go      = blank_zone || rd_valid_ff;

   assign status.start_sweep = wrap || is_clear;
   assign status.sweep_last  = wr_go && (wr_ptr_ff == ADDR_W'(CELLS - 1));

   assign mem_we    = (cmd.exec && is_print) || (cmd.sweep && wr_go);
   assign mem_waddr = cmd.sweep ? wr_ptr_ff : cursor_ff;
   assign mem_wdata = cmd.sweep ? (blank_zone ? BLANK_CELL : rd_data_ff)
                                : {attr_ff, code_ff};
   assign mem_re    = (cmd.exec && is_read && idx_ok) || (cmd.sweep && rd_go);
   assign mem_raddr = cmd.sweep ? rd_ptr_ff[ADDR_W-1:0] : ADDR_W'(idx_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cell_store_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff    <= '0;
         col_ff       <= '0;
         scroll_ff    <= 1'b0;
         copy_mode_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else if (cmd.exec) begin
         if (wrap) begin
            cursor_ff <= ADDR_W'(CELLS - COLUMNS);
            col_ff    <= '0;
         end else if (is_clear) begin
            cursor_ff <= '0;
            col_ff    <= '0;
         end else begin
            cursor_ff <= ADDR_W'(cursor_in);
            col_ff    <= col_in;
         end
         scroll_ff    <= wrap;
         copy_mode_ff <= wrap;
         rd_valid_ff  <= 1'b0;
      end else if (cmd.sweep) begin
         rd_valid_ff <= rd_go;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_kind;
         code_ff <= req_char_code;
         attr_ff <= req_attribute;
         idx_ff  <= req_read_index;
      end
      if (cmd.exec) begin
         rd_ptr_ff <= CNT_W'(COLUMNS);
         wr_ptr_ff <= '0;
      end else if (cmd.sweep) begin
         if (rd_go) begin
            rd_ptr_ff <= rd_ptr_ff + CNT_W'(1);
         end
         if (wr_go) begin
            wr_ptr_ff <= wr_ptr_ff + ADDR_W'(1);
         end
      end
      if (cmd.load_rsp) begin
         rsp_cursor_ff <= CUR_W'(cursor_ff);
         rsp_scroll_ff <= scroll_ff;
         rsp_data_ff   <= (is_read && idx_ok) ? rd_data_ff : '0;
      end
   end

   assign rsp_cursor_now = rsp_cursor_ff;
   assign rsp_did_scroll = rsp_scroll_ff;
   assign rsp_cell_data  = rsp_data_ff;

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) < 32'(CELLS))
      else $error("cursor beyond screen");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < 32'(COLUMNS))
      else $error("column beyond row");

   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      scroll_ff |-> (cursor_ff == ADDR_W'(CELLS - COLUMNS)) && (col_ff == '0))
      else $error("scroll left cursor off last row start");

endmodule

`default_nettype wire

// File: sv/twc_ctrl.sv
// sequencing state machine and result valid flag
`default_nettype none

module twc_ctrl import twc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.start_sweep ? ST_SWEEP : ST_DONE;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait here while the previous result is still held
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted item not executed");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside done state");

   a_sweep_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |->
         (($past(state_ff) == ST_EXEC) || ($past(state_ff) == ST_SWEEP)))
      else $error("sweep entered without an executing item");

endmodule

`default_nettype wire

// File: sv/text_console_writer_core.sv
// text console writer: one item at a time; put, newline, backspace, read and unused kinds
// pass from the idle state through the execute and done states back to idle; the result
// is loaded in the done state, which waits while an earlier result is still held; a scroll or
// a clear adds a sweep state, with the single-write, single-read cell store sweeping one cell per cycle
// reset homes the cursor; cell contents are undefined until the first clear item
`default_nettype none

module text_console_writer_core import twc_pkg::*; #(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [KIND_W-1:0] req_kind,
   input  wire logic [CODE_W-1:0] req_char_code,
   input  wire logic [ATTR_W-1:0] req_attribute,
   input  wire logic [IDX_W-1:0]  req_read_index,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [CUR_W-1:0]       rsp_cursor_now,
   output logic                   rsp_did_scroll,
   output logic [DATA_W-1:0]      rsp_cell_data
);

   cmd_type    cmd;
   status_type status;

   twc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   twc_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_attribute  (req_attribute),
      .req_read_index (req_read_index),
      .rsp_cursor_now (rsp_cursor_now),
      .rsp_did_scroll (rsp_did_scroll),
      .rsp_cell_data  (rsp_cell_data)
   );

endmodule

`default_nettype wire
